[design/perspective_project_4d_to_2d_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the perspective projection unit
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_PROJECT_4D_TO_2D_UNIT_ASSERT_SVH
`define PERSPECTIVE_PROJECT_4D_TO_2D_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PPU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PPU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ppu_pkg.sv]
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared constants and types of the perspective projection unit.
// ----------------------------------------------------------------------------
package ppu_pkg;

    localparam int COORD_WIDTH_DEF = 20;
    localparam int FRAC_BITS_DEF   = 8;

    // Stages of one projection lane beyond COORD_WIDTH: the top quotient bit,
    // entry, multiply, rounding add, overflow check, output.
    localparam int LANE_EXTRA = 6;

    localparam int CENTER_INIT = 50;
    localparam int CAM_W_INIT  = 50;
    localparam int CAM_Z_INIT  = 150;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER = 2'd0,
        CFG_CAM_W  = 2'd1,
        CFG_CAM_Z  = 2'd2
    } t_cfg_idx;

endpackage

[design/ppu_vtx_if.sv]
// ----------------------------------------------------------------------------
// ppu_vtx_if
// Vertex input channel: valid/ready plus the four coordinates.
// ----------------------------------------------------------------------------
interface ppu_vtx_if #(
    parameter int W = ppu_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] pos_x;
    logic signed [W-1:0] pos_y;
    logic signed [W-1:0] pos_z;
    logic signed [W-1:0] pos_w;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output pos_w, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input pos_w, output ready);
endinterface

[design/ppu_scr_if.sv]
// ----------------------------------------------------------------------------
// ppu_scr_if
// Screen position output channel: valid/ready plus x and y.
// ----------------------------------------------------------------------------
interface ppu_scr_if #(
    parameter int W = ppu_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] screen_x;
    logic signed [W-1:0] screen_y;

    modport source (output valid, output screen_x, output screen_y, input ready);
    modport sink   (input valid, input screen_x, input screen_y, output ready);
endinterface

[design/perspective_project_4d_to_2d_unit.sv]
// ----------------------------------------------------------------------------
// perspective_project_4d_to_2d_unit
// Two-step perspective projection of a 4D vertex to a 2D screen point.
// ----------------------------------------------------------------------------
// Takes one vertex per clock unless stalled and gives one screen position per
// vertex, in order. A vertex passes the w step lanes, the z step lanes and the
// output buffer before o_scr.valid. Each step runs in lanes whose restoring
// divider resolves one quotient bit per stage; the w step feeds the z step
// directly. The whole pipeline advances together and stops only when the
// two-entry output buffer is full and not being drained while a result waits
// at the pipeline end. Configuration is written through i_cfg_*, by the user
// only while no transaction is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module perspective_project_4d_to_2d_unit #(
    parameter int COORD_WIDTH = ppu_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ppu_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ppu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data,
    ppu_vtx_if.sink                       i_vtx,
    ppu_scr_if.source                     o_scr
);
    import ppu_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int L = W + LANE_EXTRA;
    localparam logic [W-1:0] CENTER_RST = W'(CENTER_INIT << FRAC_BITS);
    localparam logic [W-2:0] CAM_W_RST  = (W-1)'(CAM_W_INIT << FRAC_BITS);
    localparam logic [W-2:0] CAM_Z_RST  = (W-1)'(CAM_Z_INIT << FRAC_BITS);

    logic signed [W-1:0] r_center;
    logic [W-2:0]        r_cam_w;
    logic [W-2:0]        r_cam_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= CENTER_RST;
            r_cam_w  <= CAM_W_RST;
            r_cam_z  <= CAM_Z_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER: r_center <= i_cfg_data;
                CFG_CAM_W:  r_cam_w  <= i_cfg_data[W-2:0];
                CFG_CAM_Z:  r_cam_z  <= i_cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    logic                en;
    logic signed [W-1:0] x3;
    logic signed [W-1:0] y3;
    logic signed [W-1:0] z3;
    logic signed [W-1:0] x2;
    logic signed [W-1:0] y2;

    assign i_vtx.ready = en;

    ppu_lane #(.W(W)) u_lane_x3 (
        .i_clk(i_clk), .i_en(en), .i_v(i_vtx.pos_x), .i_depth(i_vtx.pos_w),
        .i_c(r_center), .i_cam(r_cam_w), .o_res(x3));
    ppu_lane #(.W(W)) u_lane_y3 (
        .i_clk(i_clk), .i_en(en), .i_v(i_vtx.pos_y), .i_depth(i_vtx.pos_w),
        .i_c(r_center), .i_cam(r_cam_w), .o_res(y3));
    ppu_lane #(.W(W)) u_lane_z3 (
        .i_clk(i_clk), .i_en(en), .i_v(i_vtx.pos_z), .i_depth(i_vtx.pos_w),
        .i_c(r_center), .i_cam(r_cam_w), .o_res(z3));

    ppu_lane #(.W(W)) u_lane_x2 (
        .i_clk(i_clk), .i_en(en), .i_v(x3), .i_depth(z3),
        .i_c(r_center), .i_cam(r_cam_z), .o_res(x2));
    ppu_lane #(.W(W)) u_lane_y2 (
        .i_clk(i_clk), .i_en(en), .i_v(y3), .i_depth(z3),
        .i_c(r_center), .i_cam(r_cam_z), .o_res(y2));

    ppu_ctrl #(.W(W), .N(2 * L)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_vtx.valid),
        .o_en       (en),
        .i_res_x    (x2),
        .i_res_y    (y2),
        .o_scr      (o_scr)
    );

endmodule

[design/ppu_lane.sv]
// ----------------------------------------------------------------------------
// ppu_lane
// One perspective step for one coordinate: offset, scale product, restoring
// division one quotient bit per stage, clamp and add the centre back.
// ----------------------------------------------------------------------------
module ppu_lane #(
    parameter int W = ppu_pkg::COORD_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_v,
    input  logic signed [W-1:0] i_depth,
    input  logic signed [W-1:0] i_c,
    input  logic [W-2:0]        i_cam,
    output logic signed [W-1:0] o_res
);
    import ppu_pkg::*;

    localparam int L    = W + LANE_EXTRA;
    localparam int NW   = 2 * W;
    localparam int LAST = L - 2;
    localparam logic [W+1:0] LIM = {1'b1, {(W+1){1'b0}}};
    localparam logic signed [W+2:0] SMAX = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [W+2:0] SMIN = {4'b1111, {(W-1){1'b0}}};

    // entry stage
    logic [W:0]   off;
    logic         neg0;
    logic [W:0]   mag0;
    logic [W-2:0] cam1;
    logic         dpos;
    logic [W-1:0] x0;
    logic [W:0]   d0;

    always_comb begin
        off  = {i_v[W-1], i_v} - {i_c[W-1], i_c};
        neg0 = off[W];
        mag0 = neg0 ? (~off + (W+1)'(1)) : off;
        cam1 = (i_cam == '0) ? (W-1)'(1) : i_cam;
        dpos = !i_depth[W-1] && (i_depth != '0);
        x0   = dpos ? {1'b0, cam1} : (~i_depth + W'(1));
        d0   = dpos ? ({2'b00, cam1} + {1'b0, i_depth}) : {2'b00, cam1};
    end

    logic [W:0]    r_mag [0:LAST];
    logic          r_neg [0:LAST];
    logic          r_add [0:LAST];
    logic          r_ovf [0:LAST];
    logic [W:0]    r_d   [0:LAST];
    logic [NW-1:0] r_rem [0:LAST];
    logic [W:0]    r_q   [0:LAST];
    logic [W-1:0]  r_x0;
    logic signed [W-1:0] r_res;

    logic [NW:0]   prod;
    logic          ovf3;
    logic [NW:0]   dsh [0:LAST];
    logic          ge  [0:LAST];

    always_comb begin
        prod = (NW+1)'(r_mag[0] * r_x0);
        ovf3 = {2'b00, r_rem[2]} >= {r_d[2], (W+1)'(0)};
        for (int k = 0; k <= LAST; k++) begin
            if (k >= 4) begin
                dsh[k] = (NW+1)'(r_d[k-1]) << (LAST - k);
                ge[k]  = {1'b0, r_rem[k-1]} >= dsh[k];
            end else begin
                dsh[k] = '0;
                ge[k]  = 1'b0;
            end
        end
    end

    // output stage: add the magnitude back when depth was not positive, clamp, add the centre and saturate
    logic [W+1:0]        tq;
    logic [W+1:0]        tc;
    logic [W+2:0]        tce;
    logic signed [W+2:0] sm;
    logic signed [W-1:0] n_res;

    always_comb begin
        tq  = r_add[LAST] ? ({1'b0, r_mag[LAST]} + {1'b0, r_q[LAST]})
                          : {1'b0, r_q[LAST]};
        tc  = (r_ovf[LAST] || (tq > LIM)) ? LIM : tq;
        tce = {1'b0, tc};
        sm  = {{3{i_c[W-1]}}, i_c} + (r_neg[LAST] ? (~tce + (W+3)'(1)) : tce);
        if (sm > SMAX) begin
            n_res = SMAX[W-1:0];
        end else if (sm < SMIN) begin
            n_res = SMIN[W-1:0];
        end else begin
            n_res = sm[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag[0] <= mag0;
            r_neg[0] <= neg0;
            r_add[0] <= !dpos;
            r_ovf[0] <= 1'b0;
            r_d[0]   <= d0;
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_x0     <= x0;
            for (int k = 1; k <= LAST; k++) begin
                r_mag[k] <= r_mag[k-1];
                r_neg[k] <= r_neg[k-1];
                r_add[k] <= r_add[k-1];
                r_d[k]   <= r_d[k-1];
                r_ovf[k] <= (k == 3) ? ovf3 : r_ovf[k-1];
                if (k == 1) begin
                    r_rem[k] <= prod[NW-1:0];
                end else if (k == 2) begin
                    r_rem[k] <= r_rem[k-1] + NW'(r_d[k-1] >> 1);
                end else if ((k >= 4) && ge[k]) begin
                    r_rem[k] <= r_rem[k-1] - dsh[k][NW-1:0];
                end else begin
                    r_rem[k] <= r_rem[k-1];
                end
                if (k >= 4) begin
                    r_q[k] <= {r_q[k-1][W-1:0], ge[k]};
                end else begin
                    r_q[k] <= r_q[k-1];
                end
            end
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

[design/ppu_ctrl.sv]
// ----------------------------------------------------------------------------
// ppu_ctrl
// Pipeline valid bits, global advance and a two-entry output buffer.
// ----------------------------------------------------------------------------
`include "perspective_project_4d_to_2d_unit_assert.svh"

module ppu_ctrl #(
    parameter int W = ppu_pkg::COORD_WIDTH_DEF,
    parameter int N = 2 * (ppu_pkg::COORD_WIDTH_DEF + ppu_pkg::LANE_EXTRA)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_en,
    input  logic signed [W-1:0] i_res_x,
    input  logic signed [W-1:0] i_res_y,
    ppu_scr_if.source           o_scr
);
    import ppu_pkg::*;

    logic [N-1:0]        r_vld;
    logic [1:0]          r_cnt;
    logic                r_wp;
    logic                r_rp;
    logic signed [W-1:0] r_bx [0:1];
    logic signed [W-1:0] r_by [0:1];

    logic       en;
    logic       push;
    logic       pop;
    logic [1:0] n_cnt;

    // advance unless the buffer is full, stays full and a result is waiting
    assign en    = (r_cnt != 2'd2) || o_scr.ready || !r_vld[N-1];
    assign push  = en && r_vld[N-1];
    assign pop   = (r_cnt != 2'd0) && o_scr.ready;
    assign n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    assign o_en  = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[N-2:0], i_in_valid};
            end
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_bx[r_wp] <= i_res_x;
            r_by[r_wp] <= i_res_y;
        end
    end

    assign o_scr.valid    = (r_cnt != 2'd0);
    assign o_scr.screen_x = r_bx[r_rp];
    assign o_scr.screen_y = r_by[r_rp];

    `PPU_ASSERT_IMP(a_no_overflow, (r_cnt == 2'd2) && !o_scr.ready && r_vld[N-1], !en, "buffer overrun")
    `PPU_ASSERT_IMP(a_cnt_range, 1'b1, r_cnt != 2'd3, "buffer count out of range")
    `PPU_ASSERT_NXT(a_cnt_inc, push && !pop, r_cnt == $past(r_cnt) + 2'd1, "push not counted")
    `PPU_ASSERT_NXT(a_last_hold, r_vld[N-1] && !en, r_vld[N-1], "stalled result lost")

endmodule

[dv/perspective_project_4d_to_2d_unit_tb.sv]
// ----------------------------------------------------------------------------
// perspective_project_4d_to_2d_unit_tb
// Streams 4D vertices through the projection unit under random idling and
// compares every screen position with a bit-accurate fixed-point projection.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class projection_scoreboard;
    int unsigned              COORD_W = 20;
    longint                   center;
    longint unsigned          cam_w;
    longint unsigned          cam_z;
    logic signed [19:0]       want_x [$];
    logic signed [19:0]       want_y [$];
    int                       mismatches;

    function void set_defaults();
        center = 50 * 256;
        cam_w  = 50 * 256;
        cam_z  = 150 * 256;
    endfunction

    function longint clamp20(longint v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    // one perspective step: centre plus the offset scaled by depth
    function longint scale_step(longint v, longint c, longint unsigned cam, longint depth);
        longint          offs;
        bit              neg;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned den;
        offs = v - c;
        neg  = offs < 0;
        mag  = neg ? longint'(-offs) : longint'(offs);
        if (cam == 0) cam = 1;
        if (depth > 0) begin
            den = cam + longint'(depth);
            q = (mag * cam + den / 2) / den;
        end else begin
            q = mag + (mag * longint'(-depth) + cam / 2) / cam;
        end
        if (q > (64'd1 << 21)) q = 64'd1 << 21;
        return clamp20(c + (neg ? -longint'(q) : longint'(q)));
    endfunction

    function void note_vertex(logic signed [19:0] x, logic signed [19:0] y,
                              logic signed [19:0] z, logic signed [19:0] w);
        longint x3, y3, z3;
        x3 = scale_step(x, center, cam_w, w);
        y3 = scale_step(y, center, cam_w, w);
        z3 = scale_step(z, center, cam_w, w);
        want_x.push_back(20'(scale_step(x3, center, cam_z, z3)));
        want_y.push_back(20'(scale_step(y3, center, cam_z, z3)));
    endfunction

    function void check_screen(logic signed [19:0] sx, logic signed [19:0] sy);
        logic signed [19:0] ex, ey;
        if (want_x.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result x=%0d y=%0d", sx, sy);
            return;
        end
        ex = want_x.pop_front();
        ey = want_y.pop_front();
        if (sx !== ex || sy !== ey) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                         ex, ey, sx, sy);
        end
    endfunction
endclass

module perspective_project_4d_to_2d_unit_tb;
    import ppu_pkg::*;

    localparam int LATENCY = 2 * (COORD_WIDTH_DEF + LANE_EXTRA) + 4;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [19:0] i_cfg_data;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          hold_cycles;
    int          sent;

    projection_scoreboard board;

    ppu_vtx_if vtx ();
    ppu_scr_if scr ();

    perspective_project_4d_to_2d_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_vtx     (vtx.sink),
        .o_scr     (scr.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sink side: random ready, long hold-offs on request
    always @(posedge i_clk) begin
        if (i_rst_n && scr.valid && scr.ready) board.check_screen(scr.screen_x, scr.screen_y);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            scr.ready   <= 1'b0;
        end else begin
            scr.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [19:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CENTER: board.center = longint'($signed(value));
            CFG_CAM_W:  board.cam_w  = value[18:0];
            CFG_CAM_Z:  board.cam_z  = value[18:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // one vertex transaction; valid drops only while the sender idles
    task automatic send_vertex(logic [19:0] x, logic [19:0] y, logic [19:0] z,
                               logic [19:0] w);
        while ($urandom_range(99) < src_idle_pct) begin
            vtx.valid <= 1'b0;
            @(posedge i_clk);
        end
        vtx.valid <= 1'b1;
        vtx.pos_x <= x;
        vtx.pos_y <= y;
        vtx.pos_z <= z;
        vtx.pos_w <= w;
        @(posedge i_clk);
        while (!vtx.ready) @(posedge i_clk);
        board.note_vertex(x, y, z, w);
        sent++;
    endtask

    task automatic drain();
        vtx.valid <= 1'b0;
        while (board.want_x.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [19:0] rand_coord();
        case ($urandom_range(3))
            0:       return 20'($urandom);
            1:       return 20'($signed($urandom_range(20000)) - 10000);
            2:       return $urandom_range(1) ? 20'h7ffff : 20'h80000;
            default: return 20'($signed($urandom_range(100000)) - 50000);
        endcase
    endfunction

    task automatic random_burst(int count);
        repeat (count) send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    initial begin
        board = new();
        board.set_defaults();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_CENTER;
        i_cfg_data = '0;
        vtx.valid = 1'b0;
        vtx.pos_x = '0;
        vtx.pos_y = '0;
        vtx.pos_z = '0;
        vtx.pos_w = '0;
        scr.ready = 1'b0;
        src_idle_pct = 9;
        snk_idle_pct = 60;
        hold_cycles = 0;
        sent = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zero and negative depths, ties around the centre
        send_vertex(20'h7ffff, 20'h80000, 20'h7ffff, 20'h7ffff);
        send_vertex(20'h80000, 20'h7ffff, 20'h80000, 20'h80000);
        send_vertex(20'd12800, 20'd12800, 20'd0, 20'd0);
        send_vertex(20'd12801, 20'd12799, 20'd1, 20'h80000);
        send_vertex(20'h80000, 20'h80000, 20'h7ffff, 20'h80000);
        send_vertex(20'd0, 20'd25600, -20'sd256, 20'd256);
        send_vertex(20'h55555, 20'haaaaa, 20'h55555, 20'haaaaa);
        send_vertex(20'haaaaa, 20'h55555, 20'haaaaa, 20'h55555);
        send_vertex(20'd13056, 20'd12544, 20'd12800, -20'sd12800);
        send_vertex(20'd1, 20'hfffff, 20'hfffff, 20'd1);
        drain();

        // zero camera distances act as one LSB
        write_reg(CFG_CAM_W, 20'd0);
        write_reg(CFG_CAM_Z, 20'd0);
        write_reg(CFG_CENTER, 20'h80000);
        send_vertex(20'h7ffff, 20'd5, 20'd3, 20'd1);
        send_vertex(20'd5, 20'h80000, 20'h80000, 20'h80000);
        random_burst(60);
        drain();

        write_reg(CFG_CAM_W, 20'h7ffff);
        write_reg(CFG_CAM_Z, 20'hfffff);
        write_reg(CFG_CENTER, 20'h7ffff);
        send_vertex(20'h80000, 20'h7ffff, 20'h80000, 20'h80000);
        random_burst(120);
        // receiver holds off while the sender keeps offering
        hold_cycles = 400;
        random_burst(120);
        drain();

        src_idle_pct = 60;
        snk_idle_pct = 9;
        write_reg(CFG_CENTER, 20'h80000 + 20'($urandom_range(1000)));
        write_reg(CFG_CAM_W, 20'($urandom_range(1, 524287)));
        write_reg(CFG_CAM_Z, 20'($urandom_range(1, 65535)));
        random_burst(200);
        drain();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        board.set_defaults();
        write_reg(CFG_CENTER, 20'd12800);
        write_reg(CFG_CAM_W, 20'd12800);
        write_reg(CFG_CAM_Z, 20'd38400);
        random_burst(300);
        drain();

        if (board.mismatches == 0 && board.want_x.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end
endmodule

[files.f]
+incdir+design
design/ppu_pkg.sv
design/ppu_vtx_if.sv
design/ppu_scr_if.sv
design/ppu_lane.sv
design/ppu_ctrl.sv
design/perspective_project_4d_to_2d_unit.sv
dv/perspective_project_4d_to_2d_unit_tb.sv
